// ----- hdl/srrf_pkg.sv -----
// Shared types and constants for the serial read request framer.
`timescale 1ns / 1ps

package srrf_pkg;

    // Input operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_RX    = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Final status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_ACK     = 3'd1;
    localparam logic [2:0] ST_BAD_START  = 3'd2;
    localparam logic [2:0] ST_ZERO_LEN   = 3'd3;
    localparam logic [2:0] ST_BAD_SUM    = 3'd4;
    localparam logic [2:0] ST_BAD_HEADER = 3'd5;

    // Protocol bytes.
    localparam logic [7:0] BYTE_FRAME_START = 8'h41;
    localparam logic [7:0] BYTE_ACK         = 8'h06;
    localparam logic [7:0] BYTE_ONE         = 8'h01;
    localparam logic [7:0] BYTE_ZERO        = 8'h00;
    localparam logic [7:0] REQ_LEN          = 8'd5;   // type + subcommand + address + length

    // Body offset of the first payload byte (frame offset 7).
    localparam logic [7:0] PAYLOAD_OFFSET = 8'd5;

    // Single result produced by the receive checker.
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] value;
        logic [2:0] status;
    } rx_res_t;

endpackage

// ----- hdl/srrf_rx_check.sv -----
// Receive-side checker: tracks the answer frame and produces payload and status results.
`timescale 1ns / 1ps

module srrf_rx_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_take,    // an input transaction is accepted
    input  logic                item_op,
    input  logic [7:0]          item_rlen,
    input  logic [7:0]          item_rx,
    output srrf_pkg::rx_res_t   res
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ACK   = 3'd1;
    localparam logic [2:0] PH_START = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] index_reg, index_next;
    logic [7:0] flen_reg, flen_next;
    logic [7:0] rlen_reg, rlen_next;
    logic       hdr_bad_reg, hdr_bad_next;
    logic [7:0] pay_pos;

    assign pay_pos = index_reg - srrf_pkg::PAYLOAD_OFFSET;

    // Next state and result for one accepted transaction.
    always_comb begin
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        index_next   = index_reg;
        flen_next    = flen_reg;
        rlen_next    = rlen_reg;
        hdr_bad_next = hdr_bad_reg;
        res          = '0;
        if (item_take) begin
            if (item_op == srrf_pkg::OP_START) begin
                // A start always restarts the transaction.
                rlen_next    = item_rlen;
                sum_next     = '0;
                index_next   = '0;
                flen_next    = '0;
                hdr_bad_next = 1'b0;
                phase_next   = PH_ACK;
            end else begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        phase_next = PH_IDLE;
                    end
                    PH_ACK: begin
                        if (item_rx != srrf_pkg::BYTE_ACK) begin
                            res.valid  = 1'b1;
                            res.kind   = srrf_pkg::KIND_STATUS;
                            res.status = srrf_pkg::ST_NO_ACK;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_START;
                        end
                    end
                    PH_START: begin
                        if (item_rx != srrf_pkg::BYTE_FRAME_START) begin
                            res.valid  = 1'b1;
                            res.kind   = srrf_pkg::KIND_STATUS;
                            res.status = srrf_pkg::ST_BAD_START;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (item_rx == srrf_pkg::BYTE_ZERO) begin
                            res.valid  = 1'b1;
                            res.kind   = srrf_pkg::KIND_STATUS;
                            res.status = srrf_pkg::ST_ZERO_LEN;
                            phase_next = PH_IDLE;
                        end else begin
                            // A one-byte body cannot hold the subcommand.
                            flen_next    = item_rx;
                            sum_next     = item_rx;
                            index_next   = '0;
                            hdr_bad_next = (item_rx < 8'd2);
                            phase_next   = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (index_reg >= flen_reg) begin
                            // Sum byte closes the frame; a bad sum wins over a bad header.
                            res.valid = 1'b1;
                            res.kind  = srrf_pkg::KIND_STATUS;
                            if (item_rx != sum_reg) begin
                                res.status = srrf_pkg::ST_BAD_SUM;
                            end else if (hdr_bad_reg) begin
                                res.status = srrf_pkg::ST_BAD_HEADER;
                            end else begin
                                res.status = srrf_pkg::ST_OK;
                            end
                            phase_next = PH_IDLE;
                        end else begin
                            sum_next   = sum_reg + item_rx;
                            index_next = index_reg + 8'd1;
                            if ((index_reg < 8'd2) && (item_rx != srrf_pkg::BYTE_ONE)) begin
                                hdr_bad_next = 1'b1;
                            end
                            // Pass body bytes on from offset 7, up to the requested count.
                            if ((index_reg >= srrf_pkg::PAYLOAD_OFFSET) && (pay_pos < rlen_reg)) begin
                                res.valid = 1'b1;
                                res.kind  = srrf_pkg::KIND_PAYLOAD;
                                res.value = item_rx;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            sum_reg     <= '0;
            index_reg   <= '0;
            flen_reg    <= '0;
            rlen_reg    <= '0;
            hdr_bad_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            index_reg   <= index_next;
            flen_reg    <= flen_next;
            rlen_reg    <= rlen_next;
            hdr_bad_reg <= hdr_bad_next;
        end
    end

endmodule

// ----- hdl/serial_read_request_framer_core.sv -----
// Top level of the serial read request framer: input handshake, result register and request emitter.
`timescale 1ns / 1ps
// The first result of a transaction appears in the cycle after it is accepted.
// Throughput, while m_tready is high: a received byte is taken every cycle; a start emits eight
// request bytes, one per cycle, and the next transaction is taken in the cycle the last byte leaves.
// The result register frees in the same cycle it drains, so the streams run back to back.
// Reset (aresetn low, synchronous) returns the framer to idle with no result pending.

module serial_read_request_framer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[15:0], read_length[23:16], rx_byte[31:24]
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // byte_value[7:0], status[10:8], zero[15:11]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    logic              take;
    logic              op;
    logic [15:0]       addr;
    logic [7:0]        rlen;
    logic [7:0]        rx;
    srrf_pkg::rx_res_t rx_res;

    // Result register: either an eight-byte request or one single result.
    logic              busy_reg, busy_next;
    logic              is_req_reg, is_req_next;
    logic [2:0]        idx_reg, idx_next;
    logic [15:0]       addr_reg, addr_next;
    logic [7:0]        len_reg, len_next;
    logic [7:0]        sum_reg, sum_next;
    logic [1:0]        kind_reg, kind_next;
    logic [7:0]        val_reg, val_next;
    logic [2:0]        st_reg, st_next;
    logic              drain_done;
    logic [7:0]        tx_byte;

    assign op   = s_tuser[0];
    assign addr = s_tdata[15:0];
    assign rlen = s_tdata[23:16];
    assign rx   = s_tdata[31:24];

    assign drain_done = busy_reg && m_tready && (!is_req_reg || (idx_reg == 3'd7));
    assign s_tready   = !busy_reg || drain_done;
    assign take       = s_tvalid && s_tready;

    srrf_rx_check u_rx_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_take (take),
        .item_op   (op),
        .item_rlen (rlen),
        .item_rx   (rx),
        .res       (rx_res)
    );

    // Load a new result set or step through the request bytes.
    always_comb begin
        busy_next   = busy_reg;
        is_req_next = is_req_reg;
        idx_next    = idx_reg;
        addr_next   = addr_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        kind_next   = kind_reg;
        val_next    = val_reg;
        st_next     = st_reg;
        if (busy_reg && m_tready) begin
            idx_next = idx_reg + 3'd1;
            if (drain_done) begin
                busy_next = 1'b0;
            end
        end
        if (take) begin
            idx_next = '0;
            if (op == srrf_pkg::OP_START) begin
                busy_next   = 1'b1;
                is_req_next = 1'b1;
                addr_next   = addr;
                len_next    = rlen;
                sum_next    = srrf_pkg::REQ_LEN + srrf_pkg::BYTE_ZERO + srrf_pkg::BYTE_ONE
                              + addr[15:8] + addr[7:0] + rlen;
            end else begin
                busy_next   = rx_res.valid;
                is_req_next = 1'b0;
                kind_next   = rx_res.kind;
                val_next    = rx_res.value;
                st_next     = rx_res.status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            is_req_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            busy_reg   <= busy_next;
            is_req_reg <= is_req_next;
            idx_reg    <= idx_next;
        end
        addr_reg <= addr_next;
        len_reg  <= len_next;
        sum_reg  <= sum_next;
        kind_reg <= kind_next;
        val_reg  <= val_next;
        st_reg   <= st_next;
    end

    // Request byte selected by the emit index.
    always_comb begin
        unique case (idx_reg)
            3'd0:    tx_byte = srrf_pkg::BYTE_FRAME_START;
            3'd1:    tx_byte = srrf_pkg::REQ_LEN;
            3'd2:    tx_byte = srrf_pkg::BYTE_ZERO;
            3'd3:    tx_byte = srrf_pkg::BYTE_ONE;
            3'd4:    tx_byte = addr_reg[15:8];
            3'd5:    tx_byte = addr_reg[7:0];
            3'd6:    tx_byte = len_reg;
            default: tx_byte = sum_reg;
        endcase
    end

    // Output transaction.
    always_comb begin
        m_tvalid = busy_reg;
        if (is_req_reg) begin
            m_tuser = srrf_pkg::KIND_TX;
            m_tdata = {5'd0, srrf_pkg::ST_OK, tx_byte};
            m_tlast = (idx_reg == 3'd7);
        end else begin
            m_tuser = kind_reg;
            m_tdata = {5'd0, st_reg, val_reg};
            m_tlast = (kind_reg == srrf_pkg::KIND_STATUS);
        end
    end

`ifndef SYNTH
    // A start transaction shows its first request byte in the next cycle.
    a_start_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && (op == srrf_pkg::OP_START)) |=>
            (m_tvalid && (m_tuser == srrf_pkg::KIND_TX) && (idx_reg == 3'd0)))
        else $error("start transaction did not begin the request");

    // A new transaction is only taken when the result register is empty or draining.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && busy_reg) |-> drain_done)
        else $error("result register overwritten before it drained");

    // A transmit byte carries tlast only as the eighth request byte.
    a_tx_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == srrf_pkg::KIND_TX) && m_tlast) |-> (idx_reg == 3'd7))
        else $error("tlast on a transmit byte other than the checksum");

    // Payload results never carry a status code or tlast.
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == srrf_pkg::KIND_PAYLOAD)) |-> (!m_tlast && (m_tdata[10:8] == 3'd0)))
        else $error("payload result carries status or tlast");
`endif

endmodule

// ----- bench/serial_read_request_framer_core_tb.sv -----
// Self-checking testbench for the serial read request framer core.
`timescale 1ns / 1ps

module serial_read_request_framer_core_tb;

    // Protocol bytes as the link defines them, kept apart from the package.
    localparam logic [7:0] SOF_BYTE       = 8'h41;
    localparam logic [7:0] ACK_BYTE       = 8'h06;
    localparam logic [7:0] REQ_BODY_LEN   = 8'd5;
    localparam logic [7:0] REQ_TYPE       = 8'h00;
    localparam logic [7:0] REQ_SUBCOMMAND = 8'h01;
    localparam logic [7:0] HEADER_ONE     = 8'h01;
    localparam logic [7:0] PAYLOAD_START  = 8'd5;

    localparam int RANDOM_ITEMS   = 420;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    typedef enum logic [2:0] {
        LINK_IDLE,
        LINK_WAIT_ACK,
        LINK_WAIT_SOF,
        LINK_WAIT_LEN,
        LINK_BODY
    } link_phase_t;

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_NO_ACK,
        SHAPE_BAD_SOF,
        SHAPE_ZERO_LEN,
        SHAPE_CUT
    } response_shape_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [2:0] status;
        logic       last;
    } frame_result_t;

    // One directed transaction; rows with has_status expect a single status result.
    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  rlen;
        logic [7:0]  rxb;
        logic        has_status;
        logic [2:0]  status;
    } stim_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'h0;   // address[15:0], read_length[23:16], rx_byte[31:24]
    logic [0:0]  s_tuser  = 1'b0;    // op[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // byte_value[7:0], status[10:8], zero[15:11]
    logic [1:0]  m_tuser;            // kind[1:0]
    logic        m_tlast;

    // Predictor state.
    link_phase_t link_phase   = LINK_IDLE;
    logic [7:0]  body_sum     = 8'h00;
    logic [7:0]  body_count   = 8'h00;
    logic [7:0]  frame_len    = 8'h00;
    logic [7:0]  want_length  = 8'h00;
    logic        header_fault = 1'b0;

    frame_result_t awaited_results [$];
    frame_result_t step_results [$];
    frame_result_t oldest;

    int errors        = 0;
    int counted_items = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;
    int ready_mode    = 0;
    int ready_left    = 0;

    stim_row_t directed_rows [29] = '{
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'hff,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_START, 16'hffff, 8'hff, 8'h00,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'hffff, 8'hff, 8'h00,    1'b1, srrf_pkg::ST_NO_ACK},
        '{srrf_pkg::OP_START, 16'h0000, 8'h00, 8'hff,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, ACK_BYTE, 1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_START, 16'h1234, 8'h01, 8'h00,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, ACK_BYTE, 1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'h00,    1'b1, srrf_pkg::ST_BAD_START},
        '{srrf_pkg::OP_START, 16'habcd, 8'h02, 8'h00,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, ACK_BYTE, 1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, SOF_BYTE, 1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'h00,    1'b1, srrf_pkg::ST_ZERO_LEN},
        '{srrf_pkg::OP_START, 16'h00ff, 8'hff, 8'h00,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, ACK_BYTE, 1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, SOF_BYTE, 1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'h06,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'h01,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'h01,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'h00,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'h01,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'h00,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'haa,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'hb3,    1'b1, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_START, 16'h5a5a, 8'h03, 8'h00,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, ACK_BYTE, 1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, SOF_BYTE, 1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'h01,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'h00,    1'b0, srrf_pkg::ST_OK},
        '{srrf_pkg::OP_RX,    16'h0000, 8'h00, 8'h00,    1'b1, srrf_pkg::ST_BAD_SUM}
    };

    serial_read_request_framer_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic add_step_result(input logic [1:0] kind, input logic [7:0] value,
                                   input logic [2:0] status, input logic last);
        frame_result_t res;
        res.kind   = kind;
        res.value  = value;
        res.status = status;
        res.last   = last;
        step_results.push_back(res);
    endtask

    task automatic close_transaction(input logic [2:0] status);
        add_step_result(srrf_pkg::KIND_STATUS, 8'h00, status, 1'b1);
        link_phase = LINK_IDLE;
    endtask

    // Works out the results of one accepted transaction and advances the link state.
    task automatic compute_link_results(input logic op, input logic [15:0] addr,
                                        input logic [7:0] rlen, input logic [7:0] rxb);
        logic [7:0] req [0:7];
        logic [7:0] req_sum;
        req_sum = 8'h00;
        step_results.delete();
        if (op == srrf_pkg::OP_START) begin
            req[0] = SOF_BYTE;
            req[1] = REQ_BODY_LEN;
            req[2] = REQ_TYPE;
            req[3] = REQ_SUBCOMMAND;
            req[4] = addr[15:8];
            req[5] = addr[7:0];
            req[6] = rlen;
            for (int i = 1; i < 7; i++) req_sum = req_sum + req[i];
            req[7] = req_sum;
            for (int i = 0; i < 8; i++)
                add_step_result(srrf_pkg::KIND_TX, req[i], srrf_pkg::ST_OK, i == 7);
            want_length  = rlen;
            body_sum     = 8'h00;
            body_count   = 8'h00;
            frame_len    = 8'h00;
            header_fault = 1'b0;
            link_phase   = LINK_WAIT_ACK;
        end else begin
            case (link_phase)
                LINK_WAIT_ACK: begin
                    if (rxb != ACK_BYTE) close_transaction(srrf_pkg::ST_NO_ACK);
                    else link_phase = LINK_WAIT_SOF;
                end
                LINK_WAIT_SOF: begin
                    if (rxb != SOF_BYTE) close_transaction(srrf_pkg::ST_BAD_START);
                    else link_phase = LINK_WAIT_LEN;
                end
                LINK_WAIT_LEN: begin
                    if (rxb == 8'h00) begin
                        close_transaction(srrf_pkg::ST_ZERO_LEN);
                    end else begin
                        frame_len    = rxb;
                        body_sum     = rxb;
                        body_count   = 8'h00;
                        // A one-byte body cannot carry the subcommand.
                        header_fault = (rxb < 8'd2);
                        link_phase   = LINK_BODY;
                    end
                end
                LINK_BODY: begin
                    if (body_count >= frame_len) begin
                        // The checksum error wins over a header error.
                        if (rxb != body_sum) close_transaction(srrf_pkg::ST_BAD_SUM);
                        else if (header_fault) close_transaction(srrf_pkg::ST_BAD_HEADER);
                        else close_transaction(srrf_pkg::ST_OK);
                    end else begin
                        body_sum = body_sum + rxb;
                        if (body_count < 8'd2 && rxb != HEADER_ONE) header_fault = 1'b1;
                        if (body_count >= PAYLOAD_START &&
                            (body_count - PAYLOAD_START) < want_length)
                            add_step_result(srrf_pkg::KIND_PAYLOAD, rxb, srrf_pkg::ST_OK,
                                            1'b0);
                        body_count = body_count + 8'd1;
                    end
                end
                default: link_phase = LINK_IDLE;
            endcase
        end
    endtask

    // Offers one transaction in bursts with random gaps and records what it should cause.
    task automatic send_item(input logic op, input logic [15:0] addr, input logic [7:0] rlen,
                             input logic [7:0] rxb, input logic has_status,
                             input logic [2:0] status);
        int gap;
        frame_result_t typed;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {rxb, rlen, addr};
        do @(posedge aclk); while (!(s_tvalid && s_tready));

        counted_items++;
        compute_link_results(op, addr, rlen, rxb);
        if (has_status) begin
            typed.kind   = srrf_pkg::KIND_STATUS;
            typed.value  = 8'h00;
            typed.status = status;
            typed.last   = 1'b1;
            awaited_results.push_back(typed);
        end else begin
            foreach (step_results[i]) awaited_results.push_back(step_results[i]);
        end
    endtask

    // Holds the sender off until every outstanding result has been taken.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
        burst_left = 0;
    endtask

    // One request followed by a response of a random shape; cut responses end in a restart.
    task automatic run_random_transaction();
        logic [7:0] rlen;
        logic [7:0] flen;
        logic [7:0] b;
        logic [7:0] sum;
        int pick;
        int send_count;
        response_shape_t shape;
        logic [7:0] frame_bytes [$];

        case ($urandom_range(0, 9))
            0, 1:    rlen = 8'h00;
            2:       rlen = 8'hff;
            default: rlen = 8'($urandom_range(1, 8));
        endcase
        send_item(srrf_pkg::OP_START, 16'($urandom), rlen, 8'($urandom), 1'b0,
                  srrf_pkg::ST_OK);

        pick = $urandom_range(0, 99);
        if (pick < 60) shape = SHAPE_GOOD;
        else if (pick < 68) shape = SHAPE_NO_ACK;
        else if (pick < 76) shape = SHAPE_BAD_SOF;
        else if (pick < 82) shape = SHAPE_ZERO_LEN;
        else shape = SHAPE_CUT;

        case (shape)
            SHAPE_NO_ACK: begin
                do b = 8'($urandom); while (b == ACK_BYTE);
                frame_bytes.push_back(b);
            end
            SHAPE_BAD_SOF: begin
                do b = 8'($urandom); while (b == SOF_BYTE);
                frame_bytes.push_back(ACK_BYTE);
                frame_bytes.push_back(b);
            end
            SHAPE_ZERO_LEN: begin
                frame_bytes.push_back(ACK_BYTE);
                frame_bytes.push_back(SOF_BYTE);
                frame_bytes.push_back(8'h00);
            end
            default: begin
                // Mostly short bodies, now and then a long one.
                pick = $urandom_range(0, 99);
                if (pick < 80) flen = 8'($urandom_range(1, 12));
                else if (pick < 97) flen = 8'($urandom_range(13, 40));
                else flen = 8'($urandom_range(200, 255));
                frame_bytes.push_back(ACK_BYTE);
                frame_bytes.push_back(SOF_BYTE);
                frame_bytes.push_back(flen);
                sum = flen;
                for (int i = 0; i < flen; i++) begin
                    if (i < 2 && $urandom_range(0, 9) != 0) b = HEADER_ONE;
                    else b = 8'($urandom);
                    sum = sum + b;
                    frame_bytes.push_back(b);
                end
                if ($urandom_range(0, 9) == 0) sum = sum ^ 8'($urandom_range(1, 255));
                frame_bytes.push_back(sum);
            end
        endcase

        send_count = frame_bytes.size();
        if (shape == SHAPE_CUT) send_count = $urandom_range(0, frame_bytes.size() - 1);
        for (int i = 0; i < send_count; i++)
            send_item(srrf_pkg::OP_RX, 16'($urandom), 8'($urandom), frame_bytes[i], 1'b0,
                      srrf_pkg::ST_OK);

        // Stray bytes while idle.
        if (shape != SHAPE_CUT && $urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3))
                send_item(srrf_pkg::OP_RX, 16'($urandom), 8'($urandom), 8'($urandom),
                          1'b0, srrf_pkg::ST_OK);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ERROR: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result checker: every accepted transaction is matched against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t ERROR: expected none, actual kind %0d value %0d status %0d last %0d",
                         $time, m_tuser, m_tdata[7:0], m_tdata[10:8], m_tlast);
                errors++;
            end else begin
                oldest = awaited_results.pop_front();
                compare_field("kind", oldest.kind, m_tuser);
                compare_field("byte_value", oldest.value, m_tdata[7:0]);
                compare_field("status", oldest.status, m_tdata[10:8]);
                compare_field("last", oldest.last, m_tlast);
            end
        end
    end

    // Receiver back-pressure: free running, random stalls, or sparse ready pulses.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(30, 200);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 9) >= 3);
            2:       m_tready <= (ready_left[1:0] == 2'b00);
            default: m_tready <= (ready_left[3:0] == 4'b0000);
        endcase
    end

    // Watchdog on cycles without any transaction on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].op, directed_rows[r].addr, directed_rows[r].rlen,
                      directed_rows[r].rxb, directed_rows[r].has_status,
                      directed_rows[r].status);
        wait_for_drain();

        while (counted_items < RANDOM_ITEMS) begin
            run_random_transaction();
            if ($urandom_range(0, 24) == 0) wait_for_drain();
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/srrf_pkg.sv
hdl/srrf_rx_check.sv
hdl/serial_read_request_framer_core.sv
bench/serial_read_request_framer_core_tb.sv
